### rtl/ktopk_pkg.sv
// Package for the keyed top-K list merge: entry layout, sweep token, cell control,
// request and result codes. No dependencies.
package ktopk_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int LISTS_DEF   = 4;

	// Request kinds (s_axis_tuser[1:0])
	localparam logic [1:0] REQ_OFFER = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Result status (m_axis_tuser)
	localparam logic [2:0] RES_INSERTED = 3'd0;
	localparam logic [2:0] RES_REPLACED = 3'd1;
	localparam logic [2:0] RES_DROPPED  = 3'd2;
	localparam logic [2:0] RES_CLEARED  = 3'd3;
	localparam logic [2:0] RES_READ     = 3'd4;

	// One list entry, key in the low bits
	typedef struct packed {
		logic [47:0] exit_ts;
		logic [47:0] enter_ts;
		logic [19:0] rank;
		logic [47:0] value;
		logic [23:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Token that walks the cell row during an offer
	typedef struct packed {
		logic   live;     // token sits at this hop this cycle
		logic   matched;  // candidate key found, no more changes
		logic   shift;    // candidate placed, displaced entry rides in carry
		entry_t carry;
	} tok_t;

	// Row-wide cell control
	typedef struct packed {
		logic load;  // pull the addressed list into the cells
		logic zero;  // list row not valid: load zeros instead
		logic wb;    // write cell entries back to the addressed row
		logic rot;   // rotate entries one cell toward cell 0
	} cell_ctl_t;

endpackage

### rtl/ktopk_cell.sv
// One slot of the top-K row: holds that slot of every list in a small memory,
// works the sweep token and rotates for read-out. Depends on ktopk_pkg.
module ktopk_cell import ktopk_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int LISTS   = LISTS_DEF,
	localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1,
	localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [PW-1:0]   idx,
	input  cell_ctl_t       ctl,
	input  logic [LW-1:0]   addr,
	input  entry_t          cand,
	input  tok_t            tok_in,
	input  logic [PW-1:0]   pos_in,
	input  entry_t          rot_in,
	output tok_t            tok_out,
	output logic [PW-1:0]   pos_out,
	output entry_t          entry
);

	entry_t        mem_q [LISTS];
	entry_t        entry_q;
	entry_t        step_entry;
	tok_t          tok_d, tok_q;
	logic [PW-1:0] pos_d, pos_q;
	logic          key_eq, gt;

	assign key_eq = (entry_q.key == cand.key);
	assign gt     = (cand.value > entry_q.value);

	always_comb begin
		tok_d      = tok_in;
		pos_d      = pos_in;
		step_entry = entry_q;
		if (tok_in.live && !tok_in.matched) begin
			priority if (key_eq) begin
				tok_d.matched = 1'b1;
				if (tok_in.shift) begin
					// shifted run ends here; old copy of the key drops out
					step_entry = tok_in.carry;
				end else if (gt) begin
					step_entry  = cand;
					tok_d.shift = 1'b1;
					pos_d       = idx;
				end
			end else if (tok_in.shift) begin
				step_entry  = tok_in.carry;
				tok_d.carry = entry_q;
			end else if (gt) begin
				step_entry  = cand;
				tok_d.shift = 1'b1;
				tok_d.carry = entry_q;
				pos_d       = idx;
			end else begin
				step_entry = entry_q;
			end
		end
	end

	// slot storage, one row per list
	always_ff @(posedge clk) begin
		if (ctl.wb) begin
			mem_q[addr] <= entry_q;
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			entry_q <= ctl.zero ? '0 : mem_q[addr];
		end else if (ctl.rot) begin
			entry_q <= rot_in;
		end else if (tok_in.live) begin
			entry_q <= step_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			pos_q <= '0;
		end else begin
			tok_q <= tok_d;
			pos_q <= pos_d;
		end
	end

	assign tok_out = tok_q;
	assign pos_out = pos_q;
	assign entry   = entry_q;

endmodule

### rtl/keyed_top_k_list_merge.sv
// Top level of the keyed top-K list merge: request decode, sequencer, output
// register and the row of ktopk_cell slots. Depends on ktopk_pkg, ktopk_cell.
//
// Usage
//  Requests arrive on s_axis: tuser carries the request kind and the list
//  number, tdata the candidate. Results leave on m_axis: tuser is the status,
//  tdata the slot position and the entry read, tlast marks a request's final
//  beat. An offer and a clear give one beat, a read gives ENTRIES beats,
//  slot 0 first. A request of kind 3 or for a list at or above LISTS is
//  taken and dropped without a beat.
//  Timing: one request at a time; s_axis_tready is high only when the
//  sequencer is idle. An offer goes through a load that pulls the list from
//  the cell memories, a sweep in which the token walks the cell row one slot
//  a cycle, a write-back of the row, and the posting of its result beat.
//  A clear skips the load and sweep and posts its beat directly. After a load,
//  a read posts one beat a cycle while m_axis is not stalled, the row rotating toward cell 0.
//  Stall: results go through a single output register; a stalled m_axis
//  holds the sequencer at its next beat, nothing is lost. A new request can
//  be taken while the last beat still waits.
//  Reset: per-list valid bits clear at once, so every list reads as all-zero
//  entries straight out of reset; there is no clearing pass.
module keyed_top_k_list_merge import ktopk_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int LISTS   = LISTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [23:0] cand_key, [71:24] cand_value, [91:72] cand_rank,
	// [139:92] cand_enter, [187:140] cand_exit, [191:188] zero
	input  logic [191:0] s_axis_tdata,
	// [1:0] req_type, [3:2] list_index
	input  logic [3:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [2:0] res_position, [26:3] res_key, [74:27] res_value, [94:75] res_rank,
	// [142:95] res_enter, [190:143] res_exit, [191] zero
	output logic [191:0] m_axis_tdata,
	// [2:0] res_status
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(ENTRIES - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_SWEEP = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]       state_q;
	logic [LW-1:0]    list_q;
	entry_t           cand_q;
	logic             is_read_q;
	logic             start_q;
	logic [PW-1:0]    cnt_q;
	logic [LISTS-1:0] row_valid_q;
	logic [2:0]       pend_status_q;
	logic [PW-1:0]    pend_pos_q;

	logic             res_valid_q;
	logic [2:0]       res_status_q;
	logic [2:0]       res_pos_q;
	entry_t           res_entry_q;
	logic             res_last_q;

	logic [1:0]    req;
	logic [1:0]    lidx;
	logic [LW-1:0] list_a;
	logic          list_ok;
	logic          accept;
	logic          clear_fire;
	logic          out_free;
	logic          sweep_done;
	cell_ctl_t     ctl;
	tok_t          start_tok;

	entry_t        cell_entry [ENTRIES];
	tok_t          cell_tok   [ENTRIES];
	logic [PW-1:0] cell_pos   [ENTRIES];

	assign req        = s_axis_tuser[1:0];
	assign lidx       = s_axis_tuser[3:2];
	assign list_a     = LW'(lidx);
	assign list_ok    = (int'(lidx) < LISTS);
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign clear_fire = accept && list_ok && (req == REQ_CLEAR);
	assign out_free   = !res_valid_q || m_axis_tready;
	assign sweep_done = (state_q == S_SWEEP) && cell_tok[ENTRIES-1].live;

	always_comb begin
		ctl      = '0;
		ctl.load = (state_q == S_LOAD);
		ctl.zero = !row_valid_q[list_q];
		ctl.wb   = sweep_done;
		ctl.rot  = (state_q == S_READ) && out_free;
	end

	always_comb begin
		start_tok      = '0;
		start_tok.live = start_q;
	end

	// cell row: token walks up the indices, read-out rotates down
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ktopk_cell #(
			.ENTRIES(ENTRIES),
			.LISTS  (LISTS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (PW'(i)),
			.ctl    (ctl),
			.addr   (list_q),
			.cand   (cand_q),
			.tok_in ((i == 0) ? start_tok : cell_tok[(i == 0) ? 0 : i-1]),
			.pos_in ((i == 0) ? '0 : cell_pos[(i == 0) ? 0 : i-1]),
			.rot_in (cell_entry[(i + 1) % ENTRIES]),
			.tok_out(cell_tok[i]),
			.pos_out(cell_pos[i]),
			.entry  (cell_entry[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			is_read_q     <= 1'b0;
			start_q       <= 1'b0;
			cnt_q         <= '0;
			row_valid_q   <= '0;
			list_q        <= '0;
			pend_status_q <= RES_DROPPED;
			pend_pos_q    <= '0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && list_ok) begin
						list_q <= list_a;
						unique case (req)
							REQ_OFFER: begin
								is_read_q <= 1'b0;
								state_q   <= S_LOAD;
							end
							REQ_READ: begin
								is_read_q <= 1'b1;
								state_q   <= S_LOAD;
							end
							REQ_CLEAR: begin
								row_valid_q[list_a] <= 1'b0;
								pend_status_q       <= RES_CLEARED;
								pend_pos_q          <= '0;
								state_q             <= S_EMIT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					start_q <= !is_read_q;
					state_q <= is_read_q ? S_READ : S_SWEEP;
				end
				S_SWEEP: begin
					if (sweep_done) begin
						row_valid_q[list_q] <= 1'b1;
						if (cell_tok[ENTRIES-1].shift) begin
							pend_status_q <= cell_tok[ENTRIES-1].matched ? RES_REPLACED
								: RES_INSERTED;
							pend_pos_q    <= cell_pos[ENTRIES-1];
						end else begin
							pend_status_q <= RES_DROPPED;
							pend_pos_q    <= '0;
						end
						state_q <= S_EMIT;
					end
				end
				S_READ: begin
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST_SLOT) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_READ) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			cand_q <= entry_t'(s_axis_tdata[ENTRY_W-1:0]);
		end
		if (out_free) begin
			if (state_q == S_EMIT) begin
				res_status_q <= pend_status_q;
				res_pos_q    <= 3'(pend_pos_q);
				res_entry_q  <= '0;
				res_last_q   <= 1'b1;
			end else if (state_q == S_READ) begin
				res_status_q <= RES_READ;
				res_pos_q    <= 3'(cnt_q);
				res_entry_q  <= cell_entry[0];
				res_last_q   <= (cnt_q == LAST_SLOT);
			end
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {1'b0, res_entry_q, res_pos_q};
	assign m_axis_tuser  = res_status_q;
	assign m_axis_tlast  = res_last_q;

	// checks
	logic [ENTRIES-1:0] tok_live;
	for (genvar i = 0; i < ENTRIES; i++) begin : g_live
		assign tok_live[i] = cell_tok[i].live;
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_live))
		else $error("more than one sweep token in the cell row");

	a_clear_row: assert property (@(posedge clk) disable iff (!arst_n)
		clear_fire |=> !row_valid_q[$past(list_a)])
		else $error("cleared list still marked valid");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser == RES_READ && m_axis_tlast)
		|-> (m_axis_tdata[2:0] == 3'(LAST_SLOT)))
		else $error("read stream ended on the wrong slot");

	a_sweep_idle_in: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == S_SWEEP && tok_live == '0))
		else $error("sweep started while a token was still in flight");

endmodule
